// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HHTU_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) else $error(MSG);
`define HHTU_ASSERT_ALWAYS(LBL, CLK, PROP, MSG) \
  LBL: assert property (@(posedge CLK) PROP) else $error(MSG);
`else
`define HHTU_ASSERT(LBL, CLK, RSTN, PROP, MSG)
`define HHTU_ASSERT_ALWAYS(LBL, CLK, PROP, MSG)
`endif
`endif

// ----- hw/rtl/hhtu_pkg.sv -----
package hhtu_pkg;

  localparam int BUCKETS     = 1024;
  localparam int IDX_W       = $clog2(BUCKETS);
  localparam int HOP_RANGE   = 8;
  localparam int HOP_W       = $clog2(HOP_RANGE);
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam logic [HOP_RANGE-1:0] FULL_MAP = {HOP_RANGE{1'b1}};
  localparam logic [HOP_RANGE-1:0] ONE_MAP  = {{(HOP_RANGE-1){1'b0}}, 1'b1};

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FETCH  = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  // Unused code, handled as a fetch.
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]             op;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [VALUE_WIDTH-1:0] value_out;
  } out_rsp_t;

  typedef struct packed {
    logic                   valid;
    logic [HOP_RANGE-1:0]   map;
    logic [HOP_W-1:0]       off;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] val;
  } bucket_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLR, CMD_LATCH, CMD_RD_BASE, CMD_LK_INIT, CMD_LK_RD, CMD_LK_CHK,
    CMD_WR_REPL, CMD_RM_SLOT, CMD_RD_HOME, CMD_WR_HOME, CMD_SC_INIT, CMD_SC_RD,
    CMD_SC_CHK, CMD_HK_INIT, CMD_HJ_RD, CMD_HJ_CHK, CMD_HJJ_RD, CMD_WR_I, CMD_WR_J,
    CMD_HJJ_FREE, CMD_FIN_WR_I, CMD_WR_BASE
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       rsp_valid;
    logic [1:0] rsp_status;
  } ctrl_t;

  typedef struct packed {
    logic       clr_done;
    logic       lk_empty;
    logic       lk_hit;
    logic [1:0] op;
    logic       sc_full;
    logic       sc_free;
    logic       sc_last;
    logic       id_far;
    logic       hj_ok;
    logic       k_last;
  } stat_t;

  // Position of the lowest set bit of a neighborhood map.
  function automatic logic [HOP_W-1:0] lowbit(input logic [HOP_RANGE-1:0] m);
    logic [HOP_W-1:0] r;
    r = '0;
    for (int i = HOP_RANGE - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = HOP_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hhtu_ctrl.sv -----
`include "assert_macros.svh"

module hhtu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  hhtu_pkg::stat_t st,
  output hhtu_pkg::ctrl_t ctl
);

  typedef enum logic [24:0] {
    S_CLR      = 25'h0000001,
    S_IDLE     = 25'h0000002,
    S_LK_RD    = 25'h0000004,
    S_LK_INIT  = 25'h0000008,
    S_LK_NEXT  = 25'h0000010,
    S_LK_CHK   = 25'h0000020,
    S_HIT      = 25'h0000040,
    S_MISS     = 25'h0000080,
    S_REPL     = 25'h0000100,
    S_RM_SLOT  = 25'h0000200,
    S_RM_RD    = 25'h0000400,
    S_RM_WR    = 25'h0000800,
    S_SC_RD    = 25'h0001000,
    S_SC_CHK   = 25'h0002000,
    S_HOP_TEST = 25'h0004000,
    S_HJ_RD    = 25'h0008000,
    S_HJ_CHK   = 25'h0010000,
    S_HJJ_RD   = 25'h0020000,
    S_WR_I     = 25'h0040000,
    S_WR_J     = 25'h0080000,
    S_HJJ_RD2  = 25'h0100000,
    S_HJJ_FREE = 25'h0200000,
    S_FIN_WR_I = 25'h0400000,
    S_FIN_RD   = 25'h0800000,
    S_FIN_WR   = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    ctl.cmd        = hhtu_pkg::CMD_NONE;
    ctl.rsp_valid  = 1'b0;
    ctl.rsp_status = hhtu_pkg::ST_ABSENT;
    case (state_r)
      S_CLR: begin
        ctl.cmd = hhtu_pkg::CMD_CLR;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.cmd   = hhtu_pkg::CMD_LATCH;
          state_nxt = S_LK_RD;
        end
      end
      S_LK_RD: begin
        ctl.cmd   = hhtu_pkg::CMD_RD_BASE;
        state_nxt = S_LK_INIT;
      end
      S_LK_INIT: begin
        ctl.cmd   = hhtu_pkg::CMD_LK_INIT;
        state_nxt = S_LK_NEXT;
      end
      S_LK_NEXT: begin
        if (st.lk_empty) begin
          state_nxt = S_MISS;
        end else begin
          ctl.cmd   = hhtu_pkg::CMD_LK_RD;
          state_nxt = S_LK_CHK;
        end
      end
      S_LK_CHK: begin
        ctl.cmd   = hhtu_pkg::CMD_LK_CHK;
        state_nxt = st.lk_hit ? S_HIT : S_LK_NEXT;
      end
      S_HIT: begin
        if (st.op == hhtu_pkg::OP_INSERT) begin
          state_nxt = S_REPL;
        end else if (st.op == hhtu_pkg::OP_REMOVE) begin
          state_nxt = S_RM_SLOT;
        end else begin
          ctl.rsp_valid  = 1'b1;
          ctl.rsp_status = hhtu_pkg::ST_FOUND;
          state_nxt      = S_IDLE;
        end
      end
      S_MISS: begin
        if (st.op == hhtu_pkg::OP_INSERT) begin
          ctl.cmd   = hhtu_pkg::CMD_SC_INIT;
          state_nxt = S_SC_RD;
        end else begin
          ctl.rsp_valid = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REPL: begin
        ctl.cmd        = hhtu_pkg::CMD_WR_REPL;
        ctl.rsp_valid  = 1'b1;
        ctl.rsp_status = hhtu_pkg::ST_FOUND;
        state_nxt      = S_IDLE;
      end
      S_RM_SLOT: begin
        ctl.cmd   = hhtu_pkg::CMD_RM_SLOT;
        state_nxt = S_RM_RD;
      end
      S_RM_RD: begin
        ctl.cmd   = hhtu_pkg::CMD_RD_HOME;
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        ctl.cmd        = hhtu_pkg::CMD_WR_HOME;
        ctl.rsp_valid  = 1'b1;
        ctl.rsp_status = hhtu_pkg::ST_FOUND;
        state_nxt      = S_IDLE;
      end
      S_SC_RD: begin
        ctl.cmd   = hhtu_pkg::CMD_SC_RD;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        ctl.cmd = hhtu_pkg::CMD_SC_CHK;
        if (st.sc_full) begin
          ctl.rsp_valid  = 1'b1;
          ctl.rsp_status = hhtu_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end else if (st.sc_free) begin
          state_nxt = S_HOP_TEST;
        end else if (st.sc_last) begin
          ctl.rsp_valid  = 1'b1;
          ctl.rsp_status = hhtu_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_HOP_TEST: begin
        if (st.id_far) begin
          ctl.cmd   = hhtu_pkg::CMD_HK_INIT;
          state_nxt = S_HJ_RD;
        end else begin
          state_nxt = S_FIN_WR_I;
        end
      end
      S_HJ_RD: begin
        ctl.cmd   = hhtu_pkg::CMD_HJ_RD;
        state_nxt = S_HJ_CHK;
      end
      S_HJ_CHK: begin
        ctl.cmd = hhtu_pkg::CMD_HJ_CHK;
        if (st.hj_ok) begin
          state_nxt = S_HJJ_RD;
        end else if (st.k_last) begin
          ctl.rsp_valid  = 1'b1;
          ctl.rsp_status = hhtu_pkg::ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_HJ_RD;
        end
      end
      S_HJJ_RD: begin
        ctl.cmd   = hhtu_pkg::CMD_HJJ_RD;
        state_nxt = S_WR_I;
      end
      S_WR_I: begin
        ctl.cmd   = hhtu_pkg::CMD_WR_I;
        state_nxt = S_WR_J;
      end
      S_WR_J: begin
        ctl.cmd   = hhtu_pkg::CMD_WR_J;
        state_nxt = S_HJJ_RD2;
      end
      S_HJJ_RD2: begin
        ctl.cmd   = hhtu_pkg::CMD_HJJ_RD;
        state_nxt = S_HJJ_FREE;
      end
      S_HJJ_FREE: begin
        ctl.cmd   = hhtu_pkg::CMD_HJJ_FREE;
        state_nxt = S_HOP_TEST;
      end
      S_FIN_WR_I: begin
        ctl.cmd   = hhtu_pkg::CMD_FIN_WR_I;
        state_nxt = S_FIN_RD;
      end
      S_FIN_RD: begin
        ctl.cmd   = hhtu_pkg::CMD_RD_BASE;
        state_nxt = S_FIN_WR;
      end
      S_FIN_WR: begin
        ctl.cmd       = hhtu_pkg::CMD_WR_BASE;
        ctl.rsp_valid = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  `HHTU_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted request did not raise busy")
  `HHTU_ASSERT(a_rsp_while_busy, clk, rst_n, ctl.rsp_valid |-> busy, "response issued while idle")
  `HHTU_ASSERT(a_rsp_then_idle, clk, rst_n, ctl.rsp_valid |=> !busy, "block not idle after response")

endmodule

// ----- hw/rtl/hhtu_dp.sv -----
module hhtu_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  hhtu_pkg::in_req_t  in_req,
  input  hhtu_pkg::ctrl_t    ctl,
  output hhtu_pkg::stat_t    st,
  output logic               out_valid,
  output hhtu_pkg::out_rsp_t out_rsp
);

  localparam int IDX_W = hhtu_pkg::IDX_W;
  localparam int HOP_W = hhtu_pkg::HOP_W;
  localparam int HOP_RANGE = hhtu_pkg::HOP_RANGE;

  hhtu_pkg::bucket_t mem [hhtu_pkg::BUCKETS];
  hhtu_pkg::bucket_t rd_q;

  hhtu_pkg::in_req_t    req_r;
  logic [HOP_RANGE-1:0] map_r;
  logic [HOP_W-1:0]     d_r;
  hhtu_pkg::bucket_t    word_r;
  hhtu_pkg::bucket_t    free_r;
  hhtu_pkg::bucket_t    jword_r;
  logic [IDX_W-1:0]     ix_r;
  logic [IDX_W-1:0]     id_r;
  logic [IDX_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     clr_r;
  logic [HOP_W-1:0]     k_r;
  logic [HOP_W-1:0]     lbit_r;
  logic                 out_valid_r;
  hhtu_pkg::out_rsp_t   out_rsp_r;

  logic [IDX_W-1:0]     base, jx, jjx, home;
  logic [HOP_W-1:0]     lk_bit, rd_low;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_addr;
  hhtu_pkg::bucket_t    mem_wdata;

  assign base   = req_r.key[IDX_W-1:0];
  assign lk_bit = hhtu_pkg::lowbit(map_r);
  assign rd_low = hhtu_pkg::lowbit(rd_q.map);
  assign jx     = ix_r - {{(IDX_W-HOP_W){1'b0}}, k_r};
  assign jjx    = jx + {{(IDX_W-HOP_W){1'b0}}, lbit_r};
  assign home   = ix_r - {{(IDX_W-HOP_W){1'b0}}, word_r.off};

  always_comb begin
    st.clr_done = (clr_r == {IDX_W{1'b1}});
    st.lk_empty = (map_r == '0);
    st.lk_hit   = rd_q.valid && (rd_q.key == req_r.key);
    st.op       = req_r.op;
    st.sc_full  = (rd_q.map == hhtu_pkg::FULL_MAP);
    st.sc_free  = !rd_q.valid;
    st.sc_last  = (cnt_r == {IDX_W{1'b1}});
    st.id_far   = (id_r >= IDX_W'(HOP_RANGE));
    st.hj_ok    = (rd_q.map != '0) && (rd_low < k_r);
    st.k_last   = (k_r == HOP_W'(1));
  end

  // Memory port: one access per cycle, selected by the current command.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = rd_q;
    case (ctl.cmd)
      hhtu_pkg::CMD_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
      end
      hhtu_pkg::CMD_RD_BASE: mem_addr = base;
      hhtu_pkg::CMD_LK_RD:   mem_addr = base + {{(IDX_W-HOP_W){1'b0}}, lk_bit};
      hhtu_pkg::CMD_WR_REPL: begin
        mem_we        = 1'b1;
        mem_addr      = ix_r;
        mem_wdata     = word_r;
        mem_wdata.val = req_r.value;
      end
      hhtu_pkg::CMD_RM_SLOT: begin
        mem_we          = 1'b1;
        mem_addr        = ix_r;
        mem_wdata       = word_r;
        mem_wdata.valid = 1'b0;
      end
      hhtu_pkg::CMD_RD_HOME: mem_addr = home;
      hhtu_pkg::CMD_WR_HOME: begin
        mem_we        = 1'b1;
        mem_addr      = home;
        mem_wdata.map = rd_q.map & ~(hhtu_pkg::ONE_MAP << word_r.off);
      end
      hhtu_pkg::CMD_SC_RD:  mem_addr = base + cnt_r;
      hhtu_pkg::CMD_HJ_RD:  mem_addr = jx;
      hhtu_pkg::CMD_HJJ_RD: mem_addr = jjx;
      hhtu_pkg::CMD_WR_I: begin
        mem_we          = 1'b1;
        mem_addr        = ix_r;
        mem_wdata.valid = 1'b1;
        mem_wdata.map   = free_r.map;
        mem_wdata.off   = k_r;
        mem_wdata.key   = rd_q.key;
        mem_wdata.val   = rd_q.val;
      end
      hhtu_pkg::CMD_WR_J: begin
        mem_we        = 1'b1;
        mem_addr      = jx;
        mem_wdata     = jword_r;
        mem_wdata.map = (jword_r.map & ~(hhtu_pkg::ONE_MAP << lbit_r))
                        | (hhtu_pkg::ONE_MAP << k_r);
      end
      hhtu_pkg::CMD_HJJ_FREE: begin
        mem_we          = 1'b1;
        mem_addr        = jjx;
        mem_wdata.valid = 1'b0;
      end
      hhtu_pkg::CMD_FIN_WR_I: begin
        mem_we          = 1'b1;
        mem_addr        = ix_r;
        mem_wdata.valid = 1'b1;
        mem_wdata.map   = free_r.map;
        mem_wdata.off   = id_r[HOP_W-1:0];
        mem_wdata.key   = req_r.key;
        mem_wdata.val   = req_r.value;
      end
      hhtu_pkg::CMD_WR_BASE: begin
        mem_we        = 1'b1;
        mem_addr      = base;
        mem_wdata.map = rd_q.map | (hhtu_pkg::ONE_MAP << id_r[HOP_W-1:0]);
      end
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.cmd == hhtu_pkg::CMD_CLR) clr_r <= clr_r + IDX_W'(1);
      out_valid_r <= ctl.rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rsp_valid) begin
      out_rsp_r.status    <= ctl.rsp_status;
      out_rsp_r.value_out <= (ctl.rsp_status == hhtu_pkg::ST_FOUND) ? word_r.val : '0;
    end
    case (ctl.cmd)
      hhtu_pkg::CMD_LATCH:   req_r <= in_req;
      hhtu_pkg::CMD_LK_INIT: map_r <= rd_q.map;
      hhtu_pkg::CMD_LK_RD: begin
        d_r   <= lk_bit;
        map_r <= map_r & ~(hhtu_pkg::ONE_MAP << lk_bit);
      end
      hhtu_pkg::CMD_LK_CHK: begin
        if (st.lk_hit) begin
          ix_r   <= base + {{(IDX_W-HOP_W){1'b0}}, d_r};
          word_r <= rd_q;
        end
      end
      hhtu_pkg::CMD_SC_INIT: cnt_r <= '0;
      hhtu_pkg::CMD_SC_CHK: begin
        free_r <= rd_q;
        ix_r   <= base + cnt_r;
        id_r   <= cnt_r;
        cnt_r  <= cnt_r + IDX_W'(1);
      end
      hhtu_pkg::CMD_HK_INIT: k_r <= HOP_W'(HOP_RANGE - 1);
      hhtu_pkg::CMD_HJ_CHK: begin
        jword_r <= rd_q;
        lbit_r  <= rd_low;
        if (!st.hj_ok) k_r <= k_r - HOP_W'(1);
      end
      hhtu_pkg::CMD_HJJ_FREE: begin
        free_r <= rd_q;
        ix_r   <= jjx;
        id_r   <= id_r - {{(IDX_W-HOP_W){1'b0}}, k_r} + {{(IDX_W-HOP_W){1'b0}}, lbit_r};
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- hw/rtl/hopscotch_hash_table_unit.sv -----
// Channel   Ports                         Handshake
// request   start, busy, in_req           taken when start is high and busy is low
// result    out_valid, out_rsp            shown for one cycle, cannot be held off
//
// After reset the block runs a clearing pass over all 1024 buckets of the
// memory with busy high. A lookup reads the home bucket and then each
// neighbor named in its map; a new insert further scans the buckets for a
// free one and, when that lies too far off, moves it nearer hop by hop,
// trying the neighborhoods in turn for each hop. All steps share the single
// port of the bucket memory. The result shows in the cycle in which busy
// falls; the receiver cannot stall.
module hopscotch_hash_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hhtu_pkg::in_req_t  in_req,
  output logic               out_valid,
  output hhtu_pkg::out_rsp_t out_rsp
);

  // The controller sequences each request; the datapath owns the bucket
  // memory, which holds key, value, valid bit, neighborhood map and home
  // offset of every bucket in one word.
  hhtu_pkg::ctrl_t ctl;
  hhtu_pkg::stat_t st;

  hhtu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  hhtu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .ctl       (ctl),
    .st        (st),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
